[sv/lli_pkg.sv]
// ----------------------------------------------------------------------------
// lli_pkg
// Shared constants and types for the line-line intersection pipeline.
// ----------------------------------------------------------------------------
package lli_pkg;

  // Default coordinate width (signed Q16.16).
  localparam int COORD_BITS_DEF = 32;

  // Digit width of the digit-serial multiplier stages.
  localparam int DIGIT_BITS = 16;

  // Parallel threshold register.
  localparam int          THR_BITS  = 17;
  localparam logic [16:0] THR_RESET = 17'd66;

  // The sine test compares cross^2 * 2^32 against threshold^2 * |d0|^2 * |d1|^2.
  localparam int SINE_SHIFT = 32;

  // Register bus.
  localparam int         ADDR_BITS = 2;
  localparam int         DATA_BITS = 32;
  localparam logic [1:0] ADDR_THR  = 2'd0;

  // Sign and overflow flags of one quotient, from operand preparation to the divider.
  typedef struct packed {
    logic neg;
    logic ovf;
  } quot_ctl_t;

endpackage

[sv/lli_dly.sv]
// ----------------------------------------------------------------------------
// lli_dly
// Enabled delay line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module lli_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

[sv/lli_mul.sv]
// ----------------------------------------------------------------------------
// lli_mul
// Pipelined signed multiplier: one 16-bit digit of b is taken per stage.
// ----------------------------------------------------------------------------
module lli_mul import lli_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int ND  = (BW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BXW = ND * DIGIT_BITS;
  localparam int PW  = AW + BXW;
  localparam int XW  = AW + DIGIT_BITS + 1;

  logic signed [PW-1:0] acc [ND+1];
  logic signed [AW-1:0] ar  [ND];
  logic [BXW-1:0]       br  [ND];

  assign acc[0] = '0;
  assign ar[0]  = a;
  assign br[0]  = BXW'(b);

  for (genvar k = 0; k < ND; k++) begin : g_dig
    logic [DIGIT_BITS-1:0] dg;
    logic signed [XW-1:0]  ax;
    logic signed [XW-1:0]  bx;
    logic signed [XW-1:0]  pp;

    assign dg = br[k][k*DIGIT_BITS +: DIGIT_BITS];
    assign ax = XW'(ar[k]);
    // The top digit carries the sign of b; the others are plain magnitudes.
    if (k == ND - 1) begin : g_top
      assign bx = XW'($signed(dg));
    end else begin : g_low
      assign bx = $signed({{(AW+1){1'b0}}, dg});
    end
    assign pp = ax * bx;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k+1] <= acc[k] + (PW'(pp) <<< (k * DIGIT_BITS));
      end
    end

    if (k < ND - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          ar[k+1] <= ar[k];
          br[k+1] <= br[k];
        end
      end
    end
  end

  assign p = acc[ND][AW+BW-1:0];

endmodule

[sv/lli_prep.sv]
// ----------------------------------------------------------------------------
// lli_prep
// Three stages that turn the signed Cramer numerators and the determinant
// into the rounded-division operands 2|n|+|d| and 2|d|, with sign and
// overflow flags.
// ----------------------------------------------------------------------------
module lli_prep import lli_pkg::*; #(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [3*CW+1:0] nx,
  input  logic signed [3*CW+1:0] ny,
  input  logic signed [2*CW:0]   det,
  output logic [3*CW:0]          n2x,
  output logic [3*CW:0]          n2y,
  output logic [2*CW:0]          d2,
  output quot_ctl_t              ctl_x,
  output quot_ctl_t              ctl_y
);

  logic signed [3*CW+1:0] nx_abs;
  logic signed [3*CW+1:0] ny_abs;
  logic signed [2*CW:0]   det_abs;

  // Stage one: magnitudes.
  logic [3*CW-1:0] ax;
  logic [3*CW-1:0] ay;
  logic [2*CW-1:0] ad;
  logic            nx_neg;
  logic            ny_neg;
  logic            d_neg;

  // Stage two: rounding operands.
  logic [3*CW:0] n2x_s;
  logic [3*CW:0] n2y_s;
  logic [2*CW:0] d2_s;
  logic          sx;
  logic          sy;

  assign nx_abs  = nx[3*CW+1] ? -nx : nx;
  assign ny_abs  = ny[3*CW+1] ? -ny : ny;
  assign det_abs = det[2*CW] ? -det : det;

  always_ff @(posedge clk) begin
    if (en) begin
      ax     <= nx_abs[3*CW-1:0];
      ay     <= ny_abs[3*CW-1:0];
      ad     <= det_abs[2*CW-1:0];
      nx_neg <= nx[3*CW+1];
      ny_neg <= ny[3*CW+1];
      d_neg  <= det[2*CW];

      n2x_s <= {ax, 1'b0} + (3*CW+1)'(ad);
      n2y_s <= {ay, 1'b0} + (3*CW+1)'(ad);
      d2_s  <= {ad, 1'b0};
      sx    <= nx_neg ^ d_neg;
      sy    <= ny_neg ^ d_neg;

      // The quotient fits CW+1 bits exactly when the top of the dividend
      // stays below the divisor.
      n2x       <= n2x_s;
      n2y       <= n2y_s;
      d2        <= d2_s;
      ctl_x.neg <= sx;
      ctl_y.neg <= sy;
      ctl_x.ovf <= {1'b0, n2x_s[3*CW:CW+1]} >= d2_s;
      ctl_y.ovf <= {1'b0, n2y_s[3*CW:CW+1]} >= d2_s;
    end
  end

endmodule

[sv/lli_div.sv]
// ----------------------------------------------------------------------------
// lli_div
// Pipelined restoring divider, one quotient bit per stage, followed by a
// stage that applies the sign and saturates to the coordinate range.
// ----------------------------------------------------------------------------
module lli_div import lli_pkg::*; #(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [3*CW:0]        n2,
  input  logic [2*CW:0]        d2,
  input  quot_ctl_t            ctl,
  output logic signed [CW-1:0] q
);

  localparam int NB = CW + 1;
  localparam logic [NB-1:0] SB = NB'(1) << (CW - 1);

  logic [2*CW:0]   rem [NB];
  logic [CW:0]     lo  [NB];
  logic [2*CW:0]   dd  [NB];
  logic [NB-1:0]   qq  [NB+1];
  quot_ctl_t       cc  [NB+1];

  logic [NB-1:0] mag;
  logic [NB-1:0] sv;

  assign rem[0] = {1'b0, n2[3*CW:CW+1]};
  assign lo[0]  = n2[CW:0];
  assign dd[0]  = d2;
  assign qq[0]  = '0;
  assign cc[0]  = ctl;

  for (genvar s = 0; s < NB; s++) begin : g_bit
    logic [2*CW+1:0] t;
    logic [2*CW+1:0] diff;
    logic            ge;

    assign t    = {rem[s], lo[s][CW-s]};
    assign ge   = t >= {1'b0, dd[s]};
    assign diff = t - {1'b0, dd[s]};

    always_ff @(posedge clk) begin
      if (en) begin
        qq[s+1] <= {qq[s][NB-2:0], ge};
        cc[s+1] <= cc[s];
      end
    end

    if (s < NB - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= ge ? diff[2*CW:0] : t[2*CW:0];
          lo[s+1]  <= lo[s];
          dd[s+1]  <= dd[s];
        end
      end
    end
  end

  always_comb begin
    if (cc[NB].ovf) begin
      mag = cc[NB].neg ? SB : SB - NB'(1);
    end else if (cc[NB].neg) begin
      mag = (qq[NB] > SB) ? SB : qq[NB];
    end else begin
      mag = (qq[NB] > SB - NB'(1)) ? SB - NB'(1) : qq[NB];
    end
    sv = cc[NB].neg ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= sv[CW-1:0];
    end
  end

endmodule

[sv/line_line_intersection.sv]
// ----------------------------------------------------------------------------
// line_line_intersection
// Throughput: one line pair per cycle unless the output buffer is full;
// the divider has one stage per quotient bit and the multipliers one
// stage per 16-bit digit.
// Reset (rst, synchronous): empties the pipeline and the output buffer and
// sets the parallel threshold to 66.
// ----------------------------------------------------------------------------
//
// Each line is a point p and a direction d. In standard form a*x + b*y = c
// with a = -d_y, b = d_x and c = a*p_x + b*p_y the two lines are solved by
// Cramer's rule:
//   det = d0x*d1y - d0y*d1x
//   x   = (d1x*c0 - d0x*c1) / det
//   y   = (d1y*c0 - d0y*c1) / det
// The lines count as parallel when det is zero, or when the sine of the angle
// between them falls below the threshold, tested without any square root as
//   det^2 * 2^32 < thr^2 * |d0|^2 * |d1|^2.
// All products are exact; the quotients round to nearest with ties away from
// zero and saturate to the coordinate range.
//
// Pipeline:
//   1. Direction and point products (digit-serial multipliers).
//   2. det, |d0|^2, |d1|^2, c0 and c1.
//   3. det^2, |d0|^2*|d1|^2 and the four numerator products.
//   4. Numerators nx and ny.
//   5. Threshold product, alongside the division operand preparation.
//   6. Parallel decision, alongside the bit-per-stage dividers.
// The whole pipeline moves on a single advance enable. A two-entry output
// buffer sits behind it, so the pipeline keeps accepting beats while one
// result waits on a stalled output; it only halts when both entries are full.
// ----------------------------------------------------------------------------
module line_line_intersection import lli_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Register bus
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] first_point_x,
  input  logic signed [COORD_BITS-1:0] first_point_y,
  input  logic signed [COORD_BITS-1:0] first_dir_x,
  input  logic signed [COORD_BITS-1:0] first_dir_y,
  input  logic signed [COORD_BITS-1:0] second_point_x,
  input  logic signed [COORD_BITS-1:0] second_point_y,
  input  logic signed [COORD_BITS-1:0] second_dir_x,
  input  logic signed [COORD_BITS-1:0] second_dir_y,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         intersects,
  output logic signed [COORD_BITS-1:0] cross_x,
  output logic signed [COORD_BITS-1:0] cross_y
);

  localparam int CW   = COORD_BITS;
  localparam int PW   = 2 * CW;           // one coordinate product
  localparam int DW   = 2 * CW + 1;       // det, squared lengths, c0, c1
  localparam int FW   = 3 * CW + 1;       // numerator products
  localparam int NXW  = 3 * CW + 2;       // numerators
  localparam int SQW  = 4 * CW + 2;       // det^2 and the length product
  localparam int TW   = 2 * THR_BITS + 1; // signed threshold square
  localparam int RW   = SQW + TW;         // right side of the sine test
  localparam int NW   = (CW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NL   = (DW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NT   = (SQW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIVL = CW + 2;
  localparam int LAT  = NW + 1 + NL + 1 + NT + DIVL;
  localparam int EW   = 2 * CW + 1;
  localparam int PREP_LAT = 3;
  localparam int OPW  = 2 * (3 * CW + 1) + (2 * CW + 1) + 4;

  // --------------------------------------------------------------------------
  // Register bus: a single threshold register.
  // --------------------------------------------------------------------------
  logic [THR_BITS-1:0]   thr;
  logic [2*THR_BITS-1:0] thr_sq;
  logic                  thr_wr;

  assign pready = 1'b1;
  assign thr_wr = psel && penable && pwrite && (paddr == ADDR_THR);
  assign prdata = (paddr == ADDR_THR) ? DATA_BITS'(thr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (thr_wr) begin
      thr <= pwdata[THR_BITS-1:0];
    end
  end

  // The user must change the threshold only while the pipeline is idle; the block
  // does not enforce this. The square is simply recomputed every cycle.
  always_ff @(posedge clk) begin
    thr_sq <= (2*THR_BITS)'(thr) * (2*THR_BITS)'(thr);
  end

  // --------------------------------------------------------------------------
  // Flow control: the pipeline advances unless the output buffer is full.
  // --------------------------------------------------------------------------
  logic [1:0]     cnt;
  logic [1:0]     cnt_next;
  logic           adv;
  logic           accept;
  logic           push;
  logic           pop;
  logic [LAT-1:0] vld;

  assign in_stall = (cnt == 2'd2);
  assign adv      = !in_stall;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // --------------------------------------------------------------------------
  // Stage group 1: coordinate products.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] pa, pb;
  logic signed [PW-1:0] s0x, s0y, s1x, s1y;
  logic signed [PW-1:0] e0a, e0b, e1a, e1b;

  lli_mul #(.AW(CW), .BW(CW)) u_mul_pa  (.clk, .en(adv), .a(first_dir_x),
                                          .b(second_dir_y), .p(pa));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_pb  (.clk, .en(adv), .a(first_dir_y),
                                          .b(second_dir_x), .p(pb));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_s0x (.clk, .en(adv), .a(first_dir_x),
                                          .b(first_dir_x), .p(s0x));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_s0y (.clk, .en(adv), .a(first_dir_y),
                                          .b(first_dir_y), .p(s0y));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_s1x (.clk, .en(adv), .a(second_dir_x),
                                          .b(second_dir_x), .p(s1x));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_s1y (.clk, .en(adv), .a(second_dir_y),
                                          .b(second_dir_y), .p(s1y));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_e0a (.clk, .en(adv), .a(first_dir_y),
                                          .b(first_point_x), .p(e0a));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_e0b (.clk, .en(adv), .a(first_dir_x),
                                          .b(first_point_y), .p(e0b));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_e1a (.clk, .en(adv), .a(second_dir_y),
                                          .b(second_point_x), .p(e1a));
  lli_mul #(.AW(CW), .BW(CW)) u_mul_e1b (.clk, .en(adv), .a(second_dir_x),
                                          .b(second_point_y), .p(e1b));

  // The directions are needed again for the numerators.
  logic [4*CW-1:0]      dirs_d;
  logic signed [CW-1:0] d0x_d, d0y_d, d1x_d, d1y_d;

  lli_dly #(.WIDTH(4*CW), .DEPTH(NW+1)) u_dly_dirs (
    .clk, .en(adv),
    .d({first_dir_x, first_dir_y, second_dir_x, second_dir_y}),
    .q(dirs_d)
  );
  assign {d0x_d, d0y_d, d1x_d, d1y_d} = dirs_d;

  // --------------------------------------------------------------------------
  // Stage group 2: determinant, squared lengths and the c terms.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] det_r, len0_r, len1_r, c0_r, c1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r  <= DW'(pa)  - DW'(pb);
      len0_r <= DW'(s0x) + DW'(s0y);
      len1_r <= DW'(s1x) + DW'(s1y);
      c0_r   <= DW'(e0b) - DW'(e0a);
      c1_r   <= DW'(e1b) - DW'(e1a);
    end
  end

  // --------------------------------------------------------------------------
  // Stage group 3: squares and numerator products.
  // --------------------------------------------------------------------------
  logic signed [SQW-1:0] dsq, lsq;
  logic signed [FW-1:0]  nxa, nxb, nya, nyb;
  logic [4*FW-1:0]       nprod_d;
  logic signed [FW-1:0]  nxa_d, nxb_d, nya_d, nyb_d;
  logic [DW-1:0]         det_d;

  lli_mul #(.AW(DW), .BW(DW)) u_mul_dsq (.clk, .en(adv), .a(det_r),
                                          .b(det_r), .p(dsq));
  lli_mul #(.AW(DW), .BW(DW)) u_mul_lsq (.clk, .en(adv), .a(len0_r),
                                          .b(len1_r), .p(lsq));
  lli_mul #(.AW(DW), .BW(CW)) u_mul_nxa (.clk, .en(adv), .a(c0_r),
                                          .b(d1x_d), .p(nxa));
  lli_mul #(.AW(DW), .BW(CW)) u_mul_nxb (.clk, .en(adv), .a(c1_r),
                                          .b(d0x_d), .p(nxb));
  lli_mul #(.AW(DW), .BW(CW)) u_mul_nya (.clk, .en(adv), .a(c0_r),
                                          .b(d1y_d), .p(nya));
  lli_mul #(.AW(DW), .BW(CW)) u_mul_nyb (.clk, .en(adv), .a(c1_r),
                                          .b(d0y_d), .p(nyb));

  lli_dly #(.WIDTH(4*FW), .DEPTH(NL-NW)) u_dly_nprod (
    .clk, .en(adv), .d({nxa, nxb, nya, nyb}), .q(nprod_d)
  );
  assign {nxa_d, nxb_d, nya_d, nyb_d} = nprod_d;

  lli_dly #(.WIDTH(DW), .DEPTH(NL)) u_dly_det (
    .clk, .en(adv), .d(det_r), .q(det_d)
  );

  // --------------------------------------------------------------------------
  // Stage group 4: Cramer numerators.
  // --------------------------------------------------------------------------
  logic signed [NXW-1:0] nx_r, ny_r;
  logic signed [DW-1:0]  det4;
  logic signed [SQW-1:0] dsq4, lsq4;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= NXW'(nxa_d) - NXW'(nxb_d);
      ny_r <= NXW'(nya_d) - NXW'(nyb_d);
      det4 <= det_d;
      dsq4 <= dsq;
      lsq4 <= lsq;
    end
  end

  // --------------------------------------------------------------------------
  // Stage group 5: threshold product and division operands.
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] rhs;
  logic [SQW-1:0]       dsq5;
  logic [3*CW:0]        n2x_p, n2y_p, n2x, n2y;
  logic [2*CW:0]        d2_p, d2;
  quot_ctl_t            ctl_xp, ctl_yp, ctl_x, ctl_y;
  logic [OPW-1:0]       ops_d;

  // The narrow threshold square is the full-width operand, so each digit
  // stage only multiplies it by 16 bits of the length product.
  lli_mul #(.AW(TW), .BW(SQW)) u_mul_rhs (.clk, .en(adv), .a($signed({1'b0, thr_sq})),
                                           .b(lsq4), .p(rhs));

  lli_dly #(.WIDTH(SQW), .DEPTH(NT)) u_dly_dsq (
    .clk, .en(adv), .d(dsq4), .q(dsq5)
  );

  lli_prep #(.CW(CW)) u_prep (
    .clk, .en(adv), .nx(nx_r), .ny(ny_r), .det(det4),
    .n2x(n2x_p), .n2y(n2y_p), .d2(d2_p), .ctl_x(ctl_xp), .ctl_y(ctl_yp)
  );

  // The division operands wait here until the threshold product is ready.
  lli_dly #(.WIDTH(OPW), .DEPTH(NT-PREP_LAT)) u_dly_ops (
    .clk, .en(adv), .d({n2x_p, n2y_p, d2_p, ctl_xp, ctl_yp}), .q(ops_d)
  );
  assign {n2x, n2y, d2, ctl_x, ctl_y} = ops_d;

  // --------------------------------------------------------------------------
  // Stage group 6: parallel test and the two dividers.
  // --------------------------------------------------------------------------
  logic [RW-1:0]        lhs;
  logic                 par_r;
  logic                 par_d;
  logic signed [CW-1:0] qx, qy;

  // det^2 and the length product are never negative, so both sides compare
  // as unsigned numbers.
  assign lhs = RW'({dsq5, {SINE_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (adv) begin
      par_r <= (dsq5 == '0) || (lhs < $unsigned(rhs));
    end
  end

  lli_dly #(.WIDTH(1), .DEPTH(DIVL-1)) u_dly_par (
    .clk, .en(adv), .d(par_r), .q(par_d)
  );

  lli_div #(.CW(CW)) u_div_x (.clk, .en(adv), .n2(n2x), .d2, .ctl(ctl_x), .q(qx));
  lli_div #(.CW(CW)) u_div_y (.clk, .en(adv), .n2(n2y), .d2, .ctl(ctl_y), .q(qy));

  // --------------------------------------------------------------------------
  // Two-entry output buffer. Entry 0 drives the output ports.
  // --------------------------------------------------------------------------
  logic [EW-1:0] res_new;
  logic [EW-1:0] ent0, ent1;

  // Parallel pairs report no intersection and a zero point.
  assign res_new = par_d ? '0 : {1'b1, qx, qy};

  assign push = adv && vld[LAT-1];
  assign pop  = out_valid && !out_stall;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        ent0 <= ent1;
      end else if (push) begin
        ent0 <= res_new;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        ent0 <= res_new;
      end else begin
        ent1 <= res_new;
      end
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign {intersects, cross_x, cross_y} = ent0;

endmodule

[sv/lli_chk.sv]
// ----------------------------------------------------------------------------
// lli_chk
// Port-level checks on the line-line intersection block, bound to the top.
// ----------------------------------------------------------------------------
module lli_chk import lli_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         intersects,
  input logic signed [COORD_BITS-1:0] cross_x,
  input logic signed [COORD_BITS-1:0] cross_y
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(intersects) && $stable(cross_x) && $stable(cross_y))
    else $error("result payload changed while stalled");

  // Parallel lines carry a zero point.
  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !intersects |-> cross_x == '0 && cross_y == '0)
    else $error("non-zero point on a parallel result");

  // Reset empties the output buffer and opens the input.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output buffer not empty after reset");

endmodule

bind line_line_intersection lli_chk #(.COORD_BITS(COORD_BITS)) u_lli_chk (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_line_intersection: a directed set of line
// pairs followed by random pairs under several parallel thresholds, with an
// exact wide-integer predictor and random idling on both channels.
// ----------------------------------------------------------------------------
module tb import lli_pkg::*; ();

  localparam int W = 32;
  localparam int LATENCY = 53;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 1500;

  typedef struct packed {
    logic signed [W-1:0] p0x, p0y, d0x, d0y, p1x, p1y, d1x, d1y;
  } line_pair_t;

  typedef struct packed {
    logic          hit;
    logic [W-1:0]  x;
    logic [W-1:0]  y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  line_pair_t beat_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic intersects;
  logic signed [W-1:0] cross_x, cross_y;

  line_line_intersection #(.COORD_BITS(W)) uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .first_point_x(beat_in.p0x), .first_point_y(beat_in.p0y),
    .first_dir_x(beat_in.d0x), .first_dir_y(beat_in.d0y),
    .second_point_x(beat_in.p1x), .second_point_y(beat_in.p1y),
    .second_dir_x(beat_in.d1x), .second_dir_y(beat_in.d1y),
    .out_valid, .out_stall, .intersects, .cross_x, .cross_y
  );

  always #5 clk = ~clk;

  // The predictor's own copy of the threshold register.
  logic [THR_BITS-1:0] sine_limit = THR_RESET;

  line_pair_t pending_pairs[$];
  crossing_t  expected_crossings[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit feeding_done = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  // Round num/den to nearest with ties away from zero, then saturate. The
  // magnitudes stay well under 2^200, so 256-bit signed arithmetic is exact.
  function automatic logic [W-1:0] round_quotient(logic signed [255:0] num,
                                                  logic signed [255:0] den);
    logic neg;
    logic [255:0] n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (neg) begin
      if (q > 256'h8000_0000) return 32'h8000_0000;
      return W'(-q);
    end
    if (q > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return W'(q);
  endfunction

  function automatic crossing_t solve_pair(line_pair_t lp);
    logic signed [255:0] p0x, p0y, d0x, d0y, p1x, p1y, d1x, d1y;
    logic signed [255:0] det, c0, c1, nx, ny, len0, len1, thr;
    crossing_t r;
    p0x = lp.p0x; p0y = lp.p0y; d0x = lp.d0x; d0y = lp.d0y;
    p1x = lp.p1x; p1y = lp.p1y; d1x = lp.d1x; d1y = lp.d1y;
    r = '0;
    det = d0x * d1y - d0y * d1x;
    len0 = d0x * d0x + d0y * d0y;
    len1 = d1x * d1x + d1y * d1y;
    thr = sine_limit;
    // Square-free sine test: det^2 * 2^32 against thr^2 * |d0|^2 * |d1|^2.
    if (det == 0 || ((det * det) <<< 32) < thr * thr * len0 * len1) return r;
    c0 = -d0y * p0x + d0x * p0y;
    c1 = -d1y * p1x + d1x * p1y;
    nx = d1x * c0 - d0x * c1;
    ny = -d0y * c1 + d1y * c0;
    r.hit = 1'b1;
    r.x = round_quotient(nx, det);
    r.y = round_quotient(ny, det);
    return r;
  endfunction

  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return W'($signed($urandom_range(0, 8)) - 4) <<< 16;
      2: return W'($signed($urandom_range(0, 2000)) - 1000);
      3: return W'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic line_pair_t random_pair();
    line_pair_t lp;
    lp.p0x = rand_coord(); lp.p0y = rand_coord();
    lp.d0x = rand_coord(); lp.d0y = rand_coord();
    lp.p1x = rand_coord(); lp.p1y = rand_coord();
    // Often make the second line nearly parallel or antiparallel to the first.
    case ($urandom_range(0, 3))
      0: begin
        lp.d1x = lp.d0x + W'($signed($urandom_range(0, 6)) - 3);
        lp.d1y = lp.d0y + W'($signed($urandom_range(0, 6)) - 3);
      end
      1: begin
        lp.d1x = -lp.d0x + W'($signed($urandom_range(0, 2)) - 1);
        lp.d1y = -lp.d0y;
      end
      default: begin
        lp.d1x = rand_coord();
        lp.d1y = rand_coord();
      end
    endcase
    return lp;
  endfunction

  // Sender: beats offered from the queue, back to back or after a random gap.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      if (send_gap == 0 && pending_pairs.size() > 0 && $urandom_range(0, 1)) begin
        beat_in <= pending_pairs.pop_front();
        send_gap <= $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 19);
      end
    end else if (!in_valid) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_pairs.size() > 0) begin
        beat_in <= pending_pairs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Prediction follows acceptance: the threshold only changes while idle.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) expected_crossings.push_back(solve_pair(beat_in));
  end

  // Receiver: random stalls, and once a long hold-off to fill the pipeline.
  int unsigned stall_count = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (long_hold_req && !long_hold_done) begin
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (stall_count != 0) begin
      stall_count <= stall_count - 1;
      out_stall <= (stall_count != 1);
    end else if (out_valid && !out_stall && $urandom_range(0, 2) == 0) begin
      stall_count <= $urandom_range(0, 19);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    crossing_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_crossings.size() == 0) begin
        $display("%0t: unexpected result hit=%0b x=%h y=%h", $time, intersects,
                 cross_x, cross_y);
        errors++;
      end else begin
        want = expected_crossings.pop_front();
        if (intersects !== want.hit) begin
          $display("%0t: intersects expected %0b actual %0b", $time, want.hit, intersects);
          errors++;
        end
        if (cross_x !== want.x) begin
          $display("%0t: cross_x expected %h actual %h", $time, want.x, cross_x);
          errors++;
        end
        if (cross_y !== want.y) begin
          $display("%0t: cross_y expected %h actual %h", $time, want.y, cross_y);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || feeding_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_threshold(logic [THR_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_THR; pwdata <= DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sine_limit = value;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_crossings.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic add_pair(logic [W-1:0] a, b, c, d, e, f, g, h);
    line_pair_t lp;
    lp = {a, b, c, d, e, f, g, h};
    pending_pairs.push_back(lp);
  endtask

  localparam logic [W-1:0] ONE = 32'h0001_0000;
  localparam logic [W-1:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [W-1:0] MINC = 32'h8000_0000;

  initial begin
    logic [THR_BITS-1:0] settings[5];
    settings = '{17'd0, 17'd65536, 17'd1, 17'd66, 17'd30000};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs under the reset threshold.
    add_pair(0, 0, ONE, 0, 0, 0, 0, ONE);                    // axes cross at origin
    add_pair(ONE, 2 * ONE, ONE, ONE, 0, 0, ONE, -ONE);        // diagonals
    add_pair(0, 0, ONE, 0, 0, ONE, ONE, 0);                   // exactly parallel
    add_pair(0, 0, ONE, 0, 0, ONE, -ONE, 0);                  // antiparallel
    add_pair(0, 0, ONE, 0, 0, ONE, ONE, 1);                   // nearly parallel
    add_pair(0, 0, ONE, 0, 0, ONE, -ONE, 1);                  // nearly antiparallel
    add_pair(0, 0, 0, 0, ONE, ONE, ONE, 0);                   // zero direction
    add_pair(MAXC, MAXC, ONE, 0, MAXC, MAXC, 0, ONE);         // corner point
    add_pair(MINC, MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC); // extreme fields
    add_pair(0, MAXC, 1, 0, MAXC, 0, 1, 1);                   // far out: saturates
    add_pair(0, MINC, 1, 0, MINC, 0, 1, 1);                   // negative saturation
    add_pair(0, 0, 3, 0, 1, 1, 0, 3);                         // tiny directions
    add_pair(32'h0000_8000, 0, ONE, ONE, 0, 0, ONE, -ONE);    // point offset by one half
    add_pair(-1, -1, MINC, 0, 0, 0, 0, MINC);                 // most negative directions
    drain();

    // Random phases at several thresholds, extremes included.
    foreach (settings[k]) begin
      write_threshold(settings[k]);
      add_pair(0, 0, ONE, 0, 0, 0, 0, ONE);
      add_pair(0, 0, ONE, 0, 0, ONE, ONE, 1);
      for (int i = 0; i < 400; i++) pending_pairs.push_back(random_pair());
      // Ask the receiver for one long hold-off while beats keep coming.
      if (k == 1) long_hold_req = 1'b1;
      drain();
    end

    feeding_done = 1'b1;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
